[sv/rth_pkg.sv]
// rth_pkg: shared widths, stage counts, register indexes and word types
// for the ray/triangle hit test. Used by every file of the block.
package rth_pkg;

	localparam int CW     = 32;
	localparam int FWD_W  = 16;
	localparam int DW     = CW + 1;
	localparam int PW     = 2 * DW;
	localparam int NW     = PW + 1;
	localparam int LOW    = 34;
	localparam int HIW    = NW - LOW;
	localparam int PPLO   = LOW + 1 + DW;
	localparam int PPHI   = HIW + DW;
	localparam int CMPW   = NW + DW;
	localparam int DOTW   = CMPW + 2;
	localparam int DENW   = NW + FWD_W + 1 + 2;
	localparam int DEN_LO = DENW / 2;
	localparam int DEN_HI = DENW - DEN_LO;
	localparam int REACH  = 40000;
	localparam int REACHW = 17;
	localparam int LIMLOW = DEN_LO + 1 + REACHW;
	localparam int LIMHIW = DEN_HI + REACHW;
	localparam int LIMW   = DOTW + 2;

	localparam logic signed [REACHW-1:0] REACH_K = REACHW'(REACH);

	localparam int MAGW = NW - 1;
	localparam int MW   = 30;
	localparam int SQW  = 2 * MW;
	localparam int SW   = SQW + 2;
	localparam int RW   = 64;
	localparam int RTW  = 32;
	localparam int QW   = 17;
	localparam int QSW  = QW + 1;
	localparam int DIVW = MW + 16 + 2;
	localparam int OVW  = CW + 2;

	localparam int NORM_STEPS = 7;
	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS  = QW;

	localparam int FRONT_STAGES = 9;
	localparam int B_SQ     = NORM_STEPS + 1;
	localparam int B_SUM    = B_SQ + 1;
	localparam int B_LSQ    = B_SUM + SQRT_STEPS;
	localparam int B_DIVSET = B_LSQ + 1;
	localparam int B_LDIV   = B_DIVSET + DIV_STEPS;
	localparam int BACK_STAGES = B_LDIV + 2;

	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	localparam int PIPE_CAPACITY = FRONT_STAGES + QDEPTH + BACK_STAGES + 2;
	localparam int PEND_W        = $clog2(PIPE_CAPACITY + 2);

	localparam int CFG_IW = 3;
	localparam int CFG_DW = 32;
	localparam logic [CFG_IW-1:0] REG_ORIGIN_X  = 3'd0;
	localparam logic [CFG_IW-1:0] REG_ORIGIN_Y  = 3'd1;
	localparam logic [CFG_IW-1:0] REG_ORIGIN_Z  = 3'd2;
	localparam logic [CFG_IW-1:0] REG_FORWARD_X = 3'd3;
	localparam logic [CFG_IW-1:0] REG_FORWARD_Y = 3'd4;
	localparam logic [CFG_IW-1:0] REG_FORWARD_Z = 3'd5;
	localparam logic [FWD_W-1:0]  FORWARD_Z_RESET = 16'd16384;

	typedef struct packed {
		logic [2:0][CW-1:0]    origin;
		logic [2:0][FWD_W-1:0] forward;
	} cfg_t;

	typedef struct packed {
		logic               hit;
		logic [2:0][NW-1:0] nrm;
		logic [8:0][CW-1:0] vtx;
	} front_word_t;

	typedef struct packed {
		logic               hit;
		logic [2:0]         neg;
		logic [8:0][CW-1:0] vtx;
	} back_carry_t;

	function automatic logic signed [DW-1:0] sext_c(input logic [CW-1:0] v);
		return {v[CW-1], v};
	endfunction

	function automatic logic signed [DW-1:0] sext_f(input logic [FWD_W-1:0] v);
		return {{(DW-FWD_W){v[FWD_W-1]}}, v};
	endfunction

endpackage

[sv/ray_triangle_hit_test.sv]
// ray_triangle_hit_test: top level; config registers, front pipeline,
// word queue and back pipeline. Uses rth_pkg, rth_front, rth_queue, rth_back.
//
// channel   | handshake          | payload
// ----------+--------------------+------------------------------------
// input     | start / busy       | is_polygon, ax..cz
// result    | done (one cycle)   | hit, out_ax..out_cz
// config    | cfg_we             | cfg_index, cfg_data
//
// One word accepted per cycle while busy is low; the result strobe follows the
// accepting edge via 9 front stages, queue, 32 square-root, 17 divide stages.
// Reset clears valid bits, queue pointers and origin; forward is (0, 0, 16384).
// The receiver cannot stall; the back end drains the queue every cycle, so
// busy rises only if the queue is full.
module ray_triangle_hit_test (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        is_polygon,
	input  logic [rth_pkg::CW-1:0]      ax, ay, az, bx, by, bz, cx, cy, cz,
	input  logic                        cfg_we,
	input  logic [rth_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [rth_pkg::CFG_DW-1:0]  cfg_data,
	output logic                        done,
	output logic                        hit,
	output logic [rth_pkg::CW-1:0]      out_ax, out_ay, out_az,
	output logic [rth_pkg::CW-1:0]      out_bx, out_by, out_bz,
	output logic [rth_pkg::CW-1:0]      out_cx, out_cy, out_cz
);

	rth_pkg::cfg_t               cfg_q;
	rth_pkg::front_word_t        fw, qhead;
	logic                        fvalid, q_ne, q_full;
	logic [8:0][rth_pkg::CW-1:0] vtx_in, vtx_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin  <= '0;
			cfg_q.forward <= {rth_pkg::FORWARD_Z_RESET, {(2*rth_pkg::FWD_W){1'b0}}};
		end else if (cfg_we) begin
			unique case (cfg_index)
				rth_pkg::REG_ORIGIN_X:  cfg_q.origin[0]  <= cfg_data;
				rth_pkg::REG_ORIGIN_Y:  cfg_q.origin[1]  <= cfg_data;
				rth_pkg::REG_ORIGIN_Z:  cfg_q.origin[2]  <= cfg_data;
				rth_pkg::REG_FORWARD_X: cfg_q.forward[0] <= cfg_data[rth_pkg::FWD_W-1:0];
				rth_pkg::REG_FORWARD_Y: cfg_q.forward[1] <= cfg_data[rth_pkg::FWD_W-1:0];
				rth_pkg::REG_FORWARD_Z: cfg_q.forward[2] <= cfg_data[rth_pkg::FWD_W-1:0];
				default: ;
			endcase
		end
	end

	assign busy   = q_full;
	assign vtx_in = {cz, cy, cx, bz, by, bx, az, ay, ax};

	rth_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (start && !busy),
		.is_polygon (is_polygon),
		.vtx        (vtx_in),
		.cfg        (cfg_q),
		.out_valid  (fvalid),
		.out_word   (fw)
	);

	rth_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fvalid),
		.push_word (fw),
		.pop       (q_ne),
		.head      (qhead),
		.not_empty (q_ne),
		.full      (q_full)
	);

	rth_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (q_ne),
		.in_word  (qhead),
		.done     (done),
		.hit      (hit),
		.out_vtx  (vtx_out)
	);

	assign out_ax = vtx_out[0];
	assign out_ay = vtx_out[1];
	assign out_az = vtx_out[2];
	assign out_bx = vtx_out[3];
	assign out_by = vtx_out[4];
	assign out_bz = vtx_out[5];
	assign out_cx = vtx_out[6];
	assign out_cy = vtx_out[7];
	assign out_cz = vtx_out[8];

endmodule

[sv/rth_front.sv]
// rth_front: edge vectors, face normal, plane and edge tests, hit decision.
// Nine pipeline stages, one word per cycle. Uses rth_pkg.
module rth_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          is_polygon,
	input  logic [8:0][rth_pkg::CW-1:0]   vtx,
	input  rth_pkg::cfg_t                 cfg,
	output logic                          out_valid,
	output rth_pkg::front_word_t          out_word
);

	logic                          vld_s  [1:9];
	logic                          poly_s [1:8];
	logic [8:0][rth_pkg::CW-1:0]   vtx_s  [1:9];
	logic [2:0][rth_pkg::NW-1:0]   nrm_s  [4:9];

	logic signed [rth_pkg::DW-1:0] e1_s1 [3], e2_s1 [3], dw_s1 [3];
	logic signed [rth_pkg::DW-1:0] rel_s1 [3][3];
	logic signed [rth_pkg::DW-1:0] dw_s2 [3], dw_s3 [3], rel0_s2 [3], rel0_s3 [3];
	logic signed [rth_pkg::DW-1:0] cu [4][3], cv [4][3];
	logic signed [rth_pkg::PW-1:0] pa_s2 [4][3], pb_s2 [4][3];
	logic signed [rth_pkg::NW-1:0] cr_s3 [4][3];
	logic signed [rth_pkg::NW-1:0] dx [5][3];
	logic signed [rth_pkg::DW-1:0] dy [5][3];
	logic signed [rth_pkg::PPLO-1:0] pl_s4 [5][3];
	logic signed [rth_pkg::PPHI-1:0] ph_s4 [5][3];
	logic signed [rth_pkg::CMPW-1:0] comp_s5 [5][3];
	logic signed [rth_pkg::DOTW-1:0] dot_s6 [5];

	logic signed [rth_pkg::DENW-1:0]   den;
	logic signed [rth_pkg::LIMLOW-1:0] limlo_s7;
	logic signed [rth_pkg::LIMHIW-1:0] limhi_s7;
	logic signed [rth_pkg::DOTW-1:0]   num_s7, num_s8;
	logic signed [rth_pkg::LIMW-1:0]   lim_s8;
	logic denpos_s7, denpos_s8, numpos_s8, sall_s7, sall_s8, sall;
	logic hit_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= 9; k++) vld_s[k] <= 1'b0;
		end else begin
			vld_s[1] <= in_valid;
			for (int k = 2; k <= 9; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		poly_s[1] <= is_polygon;
		vtx_s[1]  <= vtx;
		for (int k = 2; k <= 8; k++) poly_s[k] <= poly_s[k-1];
		for (int k = 2; k <= 9; k++) vtx_s[k] <= vtx_s[k-1];
		nrm_s[4] <= {cr_s3[0][2], cr_s3[0][1], cr_s3[0][0]};
		for (int k = 5; k <= 9; k++) nrm_s[k] <= nrm_s[k-1];
		for (int i = 0; i < 3; i++) begin
			e1_s1[i] <= rth_pkg::sext_c(vtx[3+i]) - rth_pkg::sext_c(vtx[i]);
			e2_s1[i] <= rth_pkg::sext_c(vtx[6+i]) - rth_pkg::sext_c(vtx[3+i]);
			dw_s1[i] <= rth_pkg::DW'(0) - rth_pkg::sext_f(cfg.forward[i]);
			for (int k = 0; k < 3; k++)
				rel_s1[k][i] <= rth_pkg::sext_c(vtx[3*k+i]) - rth_pkg::sext_c(cfg.origin[i]);
			dw_s2[i]   <= dw_s1[i];
			dw_s3[i]   <= dw_s2[i];
			rel0_s2[i] <= rel_s1[0][i];
			rel0_s3[i] <= rel0_s2[i];
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cu[0][i] = e1_s1[i];     cv[0][i] = e2_s1[i];
			cu[1][i] = rel_s1[0][i]; cv[1][i] = rel_s1[1][i];
			cu[2][i] = rel_s1[1][i]; cv[2][i] = rel_s1[2][i];
			cu[3][i] = rel_s1[2][i]; cv[3][i] = rel_s1[0][i];
		end
	end

	for (genvar gx = 0; gx < 4; gx++) begin : g_cross
		for (genvar gi = 0; gi < 3; gi++) begin : g_comp
			localparam int I1 = (gi + 1) % 3;
			localparam int I2 = (gi + 2) % 3;
			always_ff @(posedge clk) begin
				pa_s2[gx][gi] <= cu[gx][I1] * cv[gx][I2];
				pb_s2[gx][gi] <= cu[gx][I2] * cv[gx][I1];
				cr_s3[gx][gi] <= pa_s2[gx][gi] - pb_s2[gx][gi];
			end
		end
	end

	// dot 0: den, 1..3: edge signs, 4: num
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dx[0][i] = cr_s3[0][i]; dy[0][i] = dw_s3[i];
			dx[1][i] = cr_s3[1][i]; dy[1][i] = dw_s3[i];
			dx[2][i] = cr_s3[2][i]; dy[2][i] = dw_s3[i];
			dx[3][i] = cr_s3[3][i]; dy[3][i] = dw_s3[i];
			dx[4][i] = cr_s3[0][i]; dy[4][i] = rel0_s3[i];
		end
	end

	for (genvar gd = 0; gd < 5; gd++) begin : g_dot
		for (genvar gi = 0; gi < 3; gi++) begin : g_term
			always_ff @(posedge clk) begin
				pl_s4[gd][gi] <= $signed({1'b0, dx[gd][gi][rth_pkg::LOW-1:0]}) * dy[gd][gi];
				ph_s4[gd][gi] <= $signed(dx[gd][gi][rth_pkg::NW-1:rth_pkg::LOW]) * dy[gd][gi];
				comp_s5[gd][gi] <= (rth_pkg::CMPW'(ph_s4[gd][gi]) <<< rth_pkg::LOW)
					+ rth_pkg::CMPW'(pl_s4[gd][gi]);
			end
		end
		always_ff @(posedge clk) begin
			dot_s6[gd] <= rth_pkg::DOTW'(comp_s5[gd][0]) + rth_pkg::DOTW'(comp_s5[gd][1])
				+ rth_pkg::DOTW'(comp_s5[gd][2]);
		end
	end

	assign den  = dot_s6[0][rth_pkg::DENW-1:0];
	assign sall = (dot_s6[1] > 0 && dot_s6[2] > 0 && dot_s6[3] > 0)
		|| (dot_s6[1] < 0 && dot_s6[2] < 0 && dot_s6[3] < 0);

	always_ff @(posedge clk) begin
		limlo_s7  <= $signed({1'b0, den[rth_pkg::DEN_LO-1:0]}) * rth_pkg::REACH_K;
		limhi_s7  <= $signed(den[rth_pkg::DENW-1:rth_pkg::DEN_LO]) * rth_pkg::REACH_K;
		num_s7    <= dot_s6[4];
		denpos_s7 <= den > 0;
		sall_s7   <= sall;
		lim_s8    <= (rth_pkg::LIMW'(limhi_s7) <<< rth_pkg::DEN_LO) + rth_pkg::LIMW'(limlo_s7);
		num_s8    <= num_s7;
		numpos_s8 <= num_s7 > 0;
		denpos_s8 <= denpos_s7;
		sall_s8   <= sall_s7;
		hit_s9    <= poly_s[8] && denpos_s8 && numpos_s8 && sall_s8
			&& (rth_pkg::LIMW'(num_s8) < lim_s8);
	end

	assign out_valid    = vld_s[9];
	assign out_word.hit = hit_s9;
	assign out_word.nrm = nrm_s[9];
	assign out_word.vtx = vtx_s[9];

endmodule

[sv/rth_queue.sv]
// rth_queue: short word queue between the front and back pipelines.
// Register storage, one push and one pop per cycle. Uses rth_pkg.
module rth_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  rth_pkg::front_word_t push_word,
	input  logic                 pop,
	output rth_pkg::front_word_t head,
	output logic                 not_empty,
	output logic                 full
);

	rth_pkg::front_word_t        mem_q [rth_pkg::QDEPTH];
	logic [rth_pkg::QAW-1:0]     wr_q, rd_q;
	logic [rth_pkg::QAW:0]       cnt_q;
	logic                        wr_en, rd_en;

	assign not_empty = cnt_q != '0;
	assign full      = cnt_q == (rth_pkg::QAW+1)'(rth_pkg::QDEPTH);
	assign wr_en     = push && !full;
	assign rd_en     = pop && not_empty;
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_q] <= push_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) wr_q <= wr_q + rth_pkg::QAW'(1);
			if (rd_en) rd_q <= rd_q + rth_pkg::QAW'(1);
			unique case ({wr_en, rd_en})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[sv/rth_back.sv]
// rth_back: unit normal (normalize, square sum, square root, divide) and
// saturated vertex offset. Fully pipelined, one word per cycle. Uses rth_pkg.
module rth_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  rth_pkg::front_word_t        in_word,
	output logic                        done,
	output logic                        hit,
	output logic [8:0][rth_pkg::CW-1:0] out_vtx
);

	localparam int NS  = rth_pkg::NORM_STEPS;
	localparam int SUM = rth_pkg::B_SUM;
	localparam int LSQ = rth_pkg::B_LSQ;
	localparam int DS  = rth_pkg::B_DIVSET;
	localparam int LD  = rth_pkg::B_LDIV;

	logic                  vld_s [0:LD];
	rth_pkg::back_carry_t  cy_s  [0:LD];

	logic [2:0][rth_pkg::MAGW-1:0] mag_s [0:NS];
	logic [rth_pkg::MAGW-1:0]      w_s   [0:NS-1];
	logic [2:0][rth_pkg::MW-1:0]   m_s   [rth_pkg::B_SQ:LSQ];
	logic [2:0][rth_pkg::SQW-1:0]  sq_s;
	logic [rth_pkg::RW-1:0]        x_s   [SUM:LSQ-1];
	logic [rth_pkg::RW-1:0]        r_s   [SUM:LSQ];
	logic [rth_pkg::RTW-1:0]       d_s   [DS:LD-1];
	logic [2:0][rth_pkg::DIVW-1:0] rem_s [DS:LD-1];
	logic [2:0][rth_pkg::QW-1:0]   q_s   [DS:LD];

	logic signed [rth_pkg::NW-1:0] nv [3];
	logic signed [rth_pkg::NW-1:0] am [3];
	logic [2:0][rth_pkg::MAGW-1:0] mag_in;
	logic [2:0][rth_pkg::MW-1:0]   m_top;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nv[i]     = $signed(in_word.nrm[i]);
			am[i]     = nv[i][rth_pkg::NW-1] ? -nv[i] : nv[i];
			mag_in[i] = am[i][rth_pkg::MAGW-1:0];
			m_top[i]  = mag_s[NS][i][rth_pkg::MAGW-1 -: rth_pkg::MW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= LD; k++) vld_s[k] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
			for (int k = 1; k <= LD; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		cy_s[0].hit <= in_word.hit;
		cy_s[0].vtx <= in_word.vtx;
		for (int i = 0; i < 3; i++) cy_s[0].neg[i] <= in_word.nrm[i][rth_pkg::NW-1];
		for (int k = 1; k <= LD; k++) cy_s[k] <= cy_s[k-1];
		mag_s[0] <= mag_in;
		w_s[0]   <= mag_in[0] | mag_in[1] | mag_in[2];
		m_s[rth_pkg::B_SQ] <= m_top;
		for (int i = 0; i < 3; i++) sq_s[i] <= m_top[i] * m_top[i];
		for (int k = rth_pkg::B_SQ + 1; k <= LSQ; k++) m_s[k] <= m_s[k-1];
		x_s[SUM] <= rth_pkg::RW'(rth_pkg::SW'(sq_s[0]) + rth_pkg::SW'(sq_s[1])
			+ rth_pkg::SW'(sq_s[2]));
		r_s[SUM] <= '0;
		d_s[DS]  <= (r_s[LSQ] == '0) ? rth_pkg::RTW'(1) : r_s[LSQ][rth_pkg::RTW-1:0];
		for (int i = 0; i < 3; i++)
			rem_s[DS][i] <= {m_s[LSQ][i], 16'b0} + rth_pkg::DIVW'(r_s[LSQ] >> 1);
		q_s[DS] <= '0;
	end

	// leading-one normalization, largest shift first
	for (genvar gk = 0; gk < NS; gk++) begin : g_norm
		localparam int SH = (1 << (NS - 1)) >> gk;
		logic zt;
		assign zt = w_s[gk][rth_pkg::MAGW-1 -: SH] == '0;
		always_ff @(posedge clk) begin
			for (int i = 0; i < 3; i++)
				mag_s[gk+1][i] <= zt ? (mag_s[gk][i] << SH) : mag_s[gk][i];
		end
		if (gk < NS - 1) begin : g_w
			always_ff @(posedge clk) w_s[gk+1] <= zt ? (w_s[gk] << SH) : w_s[gk];
		end
	end

	for (genvar gj = 0; gj < rth_pkg::SQRT_STEPS; gj++) begin : g_sqrt
		localparam logic [rth_pkg::RW-1:0] BIT =
			rth_pkg::RW'(1) << (2 * (rth_pkg::SQRT_STEPS - 1 - gj));
		logic [rth_pkg::RW-1:0] trial;
		logic                   take;
		assign trial = r_s[SUM+gj] + BIT;
		assign take  = x_s[SUM+gj] >= trial;
		always_ff @(posedge clk)
			r_s[SUM+gj+1] <= take ? ((r_s[SUM+gj] >> 1) + BIT) : (r_s[SUM+gj] >> 1);
		if (gj < rth_pkg::SQRT_STEPS - 1) begin : g_x
			always_ff @(posedge clk)
				x_s[SUM+gj+1] <= take ? (x_s[SUM+gj] - trial) : x_s[SUM+gj];
		end
	end

	for (genvar gj = 0; gj < rth_pkg::DIV_STEPS; gj++) begin : g_div
		localparam int J = rth_pkg::DIV_STEPS - 1 - gj;
		logic [rth_pkg::DIVW-1:0] sub;
		logic [2:0]               take;
		assign sub = rth_pkg::DIVW'(d_s[DS+gj]) << J;
		always_comb begin
			for (int i = 0; i < 3; i++) take[i] = rem_s[DS+gj][i] >= sub;
		end
		always_ff @(posedge clk) begin
			for (int i = 0; i < 3; i++)
				q_s[DS+gj+1][i] <= q_s[DS+gj][i] | (rth_pkg::QW'(take[i]) << J);
		end
		if (gj < rth_pkg::DIV_STEPS - 1) begin : g_rem
			always_ff @(posedge clk) begin
				d_s[DS+gj+1] <= d_s[DS+gj];
				for (int i = 0; i < 3; i++)
					rem_s[DS+gj+1][i] <= take[i] ? (rem_s[DS+gj][i] - sub) : rem_s[DS+gj][i];
			end
		end
	end

	logic signed [rth_pkg::QSW-1:0] qs [3];
	logic signed [rth_pkg::OVW-1:0] dv [9];
	logic [8:0][rth_pkg::CW-1:0]    sat;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qs[i] = cy_s[LD].neg[i] ? -$signed({1'b0, q_s[LD][i]})
				: $signed({1'b0, q_s[LD][i]});
		end
		for (int k = 0; k < 3; k++) begin
			for (int i = 0; i < 3; i++) begin
				dv[3*k+i] = rth_pkg::OVW'($signed(cy_s[LD].vtx[3*k+i])) - rth_pkg::OVW'(qs[i]);
				if (dv[3*k+i][rth_pkg::OVW-1:rth_pkg::CW-1] == '0
					|| dv[3*k+i][rth_pkg::OVW-1:rth_pkg::CW-1] == '1)
					sat[3*k+i] = dv[3*k+i][rth_pkg::CW-1:0];
				else if (dv[3*k+i][rth_pkg::OVW-1])
					sat[3*k+i] = {1'b1, {(rth_pkg::CW-1){1'b0}}};
				else
					sat[3*k+i] = {1'b0, {(rth_pkg::CW-1){1'b1}}};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= vld_s[LD];
	end

	always_ff @(posedge clk) begin
		hit     <= cy_s[LD].hit;
		out_vtx <= cy_s[LD].hit ? sat : '0;
	end

endmodule

[sv/rth_checker.sv]
// rth_checker: port-level assertions for ray_triangle_hit_test, bound to
// the top level. Uses rth_pkg.
module rth_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   start,
	input logic                   busy,
	input logic                   done,
	input logic                   hit,
	input logic [rth_pkg::CW-1:0] out_ax, out_ay, out_az,
	input logic [rth_pkg::CW-1:0] out_bx, out_by, out_bz,
	input logic [rth_pkg::CW-1:0] out_cx, out_cy, out_cz
);

	logic [rth_pkg::PEND_W-1:0] pending_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pending_q <= '0;
		else pending_q <= pending_q + rth_pkg::PEND_W'(start && !busy)
			- rth_pkg::PEND_W'(done);
	end

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !hit |-> out_ax == '0 && out_ay == '0 && out_az == '0 && out_bx == '0
			&& out_by == '0 && out_bz == '0 && out_cx == '0 && out_cy == '0 && out_cz == '0)
		else $error("miss word carries nonzero vertices");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> pending_q != '0)
		else $error("result word without an accepted input word");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= rth_pkg::PEND_W'(rth_pkg::PIPE_CAPACITY))
		else $error("more words in flight than the pipeline holds");

endmodule

bind ray_triangle_hit_test rth_checker u_rth_checker (.*);

[sim/tb_ray_triangle_hit_test.sv]
// tb_ray_triangle_hit_test: self-checking bench for ray_triangle_hit_test.
// Directed table then random triangles per ray setting; results are checked
// against an exact wide-integer predictor. Depends on rth_pkg and the block.
`timescale 1ns / 1ps

module tb_ray_triangle_hit_test;

	typedef logic signed [127:0] wide_t;
	typedef struct {wide_t x, y, z;} vec_t;

	typedef struct {
		logic             poly;
		logic [8:0][31:0] vtx;
		logic             typed;
		logic             typed_hit;
	} tri_t;

	typedef struct {
		logic             hit;
		logic [8:0][31:0] vtx;
	} hit_word_t;

	logic clk, arst_n, start, busy, is_polygon, cfg_we, done, hit;
	logic [rth_pkg::CW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
	logic [rth_pkg::CW-1:0] out_ax, out_ay, out_az, out_bx, out_by, out_bz;
	logic [rth_pkg::CW-1:0] out_cx, out_cy, out_cz;
	logic [rth_pkg::CFG_IW-1:0] cfg_index;
	logic [rth_pkg::CFG_DW-1:0] cfg_data;

	logic [31:0] origin [3];
	logic [15:0] forward [3];
	hit_word_t   pending [$];
	int          errors;
	bit          no_gap;

	string field_name [9] = '{"out_ax", "out_ay", "out_az", "out_bx", "out_by", "out_bz",
		"out_cx", "out_cy", "out_cz"};

	ray_triangle_hit_test DUT (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic vec_t cross3(vec_t u, vec_t w);
		vec_t r;
		r.x = u.y * w.z - u.z * w.y;
		r.y = u.z * w.x - u.x * w.z;
		r.z = u.x * w.y - u.y * w.x;
		return r;
	endfunction

	function automatic wide_t dot3(vec_t u, vec_t w);
		return u.x * w.x + u.y * w.y + u.z * w.z;
	endfunction

	function automatic logic [63:0] isqrt(logic [63:0] x);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else
				r = r >> 1;
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [31:0] sat32(longint v);
		if (v > 64'sd2147483647) return 32'h7fffffff;
		if (v < -64'sd2147483648) return 32'h80000000;
		return v[31:0];
	endfunction

	function automatic hit_word_t predict_hit(tri_t t);
		hit_word_t res;
		vec_t v [3], rel [3], e1, e2, n, d;
		wide_t den, num, s1, s2, s3, mag [3];
		logic [63:0] m [3], s, r;
		longint q [3];
		int top;
		for (int k = 0; k < 3; k++) begin
			v[k].x = wide_t'($signed(t.vtx[3*k]));
			v[k].y = wide_t'($signed(t.vtx[3*k+1]));
			v[k].z = wide_t'($signed(t.vtx[3*k+2]));
			rel[k].x = v[k].x - wide_t'($signed(origin[0]));
			rel[k].y = v[k].y - wide_t'($signed(origin[1]));
			rel[k].z = v[k].z - wide_t'($signed(origin[2]));
		end
		d.x = -wide_t'($signed(forward[0]));
		d.y = -wide_t'($signed(forward[1]));
		d.z = -wide_t'($signed(forward[2]));
		e1 = '{v[1].x - v[0].x, v[1].y - v[0].y, v[1].z - v[0].z};
		e2 = '{v[2].x - v[1].x, v[2].y - v[1].y, v[2].z - v[1].z};
		n = cross3(e1, e2);
		den = dot3(d, n);
		num = dot3(n, rel[0]);
		s1 = dot3(cross3(rel[0], rel[1]), d);
		s2 = dot3(cross3(rel[1], rel[2]), d);
		s3 = dot3(cross3(rel[2], rel[0]), d);
		res.hit = t.poly && den > 0 && num > 0 && num < den * 40000 &&
			((s1 > 0 && s2 > 0 && s3 > 0) || (s1 < 0 && s2 < 0 && s3 < 0));
		res.vtx = '0;
		if (!res.hit) return res;
		mag[0] = n.x < 0 ? -n.x : n.x;
		mag[1] = n.y < 0 ? -n.y : n.y;
		mag[2] = n.z < 0 ? -n.z : n.z;
		top = 0;
		for (int i = 0; i < 3; i++)
			for (int b = 0; b < 128; b++)
				if (mag[i][b] && b + 1 > top) top = b + 1;
		for (int i = 0; i < 3; i++)
			m[i] = top > 30 ? 64'(mag[i] >> (top - 30)) : 64'(mag[i] << (30 - top));
		s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
		r = isqrt(s);
		if (r == 0) r = 1;
		q[0] = n.x < 0 ? -longint'(((m[0] << 16) + (r >> 1)) / r) : longint'(((m[0] << 16) + (r >> 1)) / r);
		q[1] = n.y < 0 ? -longint'(((m[1] << 16) + (r >> 1)) / r) : longint'(((m[1] << 16) + (r >> 1)) / r);
		q[2] = n.z < 0 ? -longint'(((m[2] << 16) + (r >> 1)) / r) : longint'(((m[2] << 16) + (r >> 1)) / r);
		for (int k = 0; k < 3; k++)
			for (int i = 0; i < 3; i++)
				res.vtx[3*k+i] = sat32(longint'($signed(t.vtx[3*k+i])) - q[i]);
		return res;
	endfunction

	always @(posedge clk) begin
		hit_word_t want;
		logic [8:0][31:0] got;
		if (done) begin
			got = {out_cz, out_cy, out_cx, out_bz, out_by, out_bx, out_az, out_ay, out_ax};
			if (pending.size() == 0) begin
				$error("unexpected result word");
				errors++;
			end else begin
				want = pending.pop_front();
				if (hit !== want.hit) begin
					$error("hit: expected %0b, got %0b", want.hit, hit);
					errors++;
				end
				for (int i = 0; i < 9; i++)
					if (got[i] !== want.vtx[i]) begin
						$error("%s: expected %h, got %h", field_name[i], want.vtx[i], got[i]);
						errors++;
					end
			end
		end
	end

	task automatic send_tri(tri_t t);
		hit_word_t want;
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
		start <= 1;
		is_polygon <= t.poly;
		{cz, cy, cx, bz, by, bx, az, ay, ax} <= t.vtx;
		do @(posedge clk); while (busy);
		want = predict_hit(t);
		if (t.typed && want.hit !== t.typed_hit) begin
			$error("hit: expected %0b, got %0b from predictor", t.typed_hit, want.hit);
			errors++;
		end
		pending.push_back(want);
	endtask

	task automatic set_ray(logic [31:0] ox, oy, oz, logic [15:0] fx, fy, fz);
		logic [31:0] val [6];
		val = '{ox, oy, oz, {16'd0, fx}, {16'd0, fy}, {16'd0, fz}};
		start <= 0;
		@(posedge clk);
		while (pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		for (int i = 0; i < 6; i++) begin
			cfg_we <= 1;
			cfg_index <= rth_pkg::CFG_IW'(i);
			cfg_data <= val[i];
			@(posedge clk);
		end
		cfg_we <= 0;
		origin = '{ox, oy, oz};
		forward = '{fx, fy, fz};
	endtask

	function automatic tri_t random_tri();
		tri_t t;
		longint h [3], u1 [3], u2 [3], k, sc;
		t.typed = 0;
		t.typed_hit = 0;
		t.poly = $urandom_range(0, 9) != 0;
		if ($urandom_range(0, 9) < 7) begin
			k = ($urandom_range(0, 7) == 0) ? $urandom_range(30000, 60000) : $urandom_range(1, 2000);
			sc = longint'(1) << $urandom_range(4, 22);
			for (int i = 0; i < 3; i++) begin
				h[i] = longint'($signed(origin[i])) - longint'($signed(forward[i])) * k;
				u1[i] = $urandom_range(0, 2 * sc) - sc;
				u2[i] = $urandom_range(0, 2 * sc) - sc;
				t.vtx[i] = 32'(h[i] + u1[i]);
				t.vtx[3+i] = 32'(h[i] + u2[i]);
				t.vtx[6+i] = 32'(h[i] - u1[i] - u2[i]);
			end
		end else
			for (int i = 0; i < 9; i++) t.vtx[i] = $urandom;
		return t;
	endfunction

	localparam logic [31:0] ONE = 32'h0001_0000;
	localparam logic [31:0] ZN = -32'sd655360;

	tri_t directed [] = '{
		'{1'b1, {ZN, ONE, 32'h0, ZN, -ONE, ONE, ZN, -ONE, -ONE}, 1'b0, 1'b0},
		'{1'b1, {ZN, -ONE, ONE, ZN, ONE, -ONE, ZN, ONE, ONE}, 1'b0, 1'b0},
		'{1'b0, {ZN, ONE, 32'h0, ZN, -ONE, ONE, ZN, -ONE, -ONE}, 1'b1, 1'b0},
		'{1'b1, {ZN, ONE, 32'h0, ZN, -ONE, -ONE, ZN, -ONE, ONE}, 1'b0, 1'b0},
		'{1'b1, {9{32'h7fffffff}}, 1'b1, 1'b0},
		'{1'b1, {9{32'h80000000}}, 1'b1, 1'b0},
		'{1'b1, {9{32'h0}}, 1'b1, 1'b0},
		'{1'b1, {-ZN, ONE, 32'h0, -ZN, -ONE, ONE, -ZN, -ONE, -ONE}, 1'b1, 1'b0},
		'{1'b1, {-32'sd2097152000, ONE, 32'h0, -32'sd2097152000, -ONE, ONE,
			-32'sd2097152000, -ONE, -ONE}, 1'b1, 1'b0},
		'{1'b1, {ZN, ONE, 32'h0, ZN, -ONE, 32'h0, ZN, 32'h0, -ONE}, 1'b0, 1'b0},
		'{1'b1, {ZN, 32'h0, ONE, ZN, -ONE, 32'h0, ZN, ONE, -ONE}, 1'b0, 1'b0},
		'{1'b1, {32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
			32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff}, 1'b0, 1'b0},
		'{1'b1, {32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000}, 1'b0, 1'b0},
		'{1'b1, {ZN, 32'h7fff0000, 32'h0, ZN, 32'h80000000, 32'h7fffffff, ZN, 32'h80000000,
			32'h80000000}, 1'b0, 1'b0}
	};

	initial begin
		logic [15:0] f [3];
		errors = 0;
		no_gap = 0;
		arst_n = 0;
		start = 0;
		is_polygon = 0;
		{ax, ay, az, bx, by, bz, cx, cy, cz} = '0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_data = '0;
		origin = '{32'h0, 32'h0, 32'h0};
		forward = '{16'h0, 16'h0, rth_pkg::FORWARD_Z_RESET};
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (directed[i]) send_tri(directed[i]);

		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
			0: set_ray(0, 0, 0, 16'sd16384, 0, 0);
			1: set_ray(0, 0, 0, -16'sd16384, 0, 0);
			2: set_ray(0, 0, 0, 0, -16'sd16384, 0);
			3: set_ray(32'h0100_0000, 32'hff00_0000, 0, 0, 0, -16'sd16384);
			4: set_ray(0, 0, 0, 16'sd16384, 16'sd16384, -16'sd16384);
			5: set_ray($urandom, $urandom, $urandom, 0, 0, 0);
			6: set_ray(32'h7fffffff, 32'h80000000, 32'h7fffffff, 16'sd1, -16'sd1, 16'sd1);
			default: begin
				for (int i = 0; i < 3; i++) f[i] = 16'($urandom_range(0, 32768) - 16384);
				set_ray($urandom_range(0, 32'h1fffffff) - 32'h10000000,
					$urandom_range(0, 32'h1fffffff) - 32'h10000000,
					$urandom_range(0, 32'h1fffffff) - 32'h10000000, f[0], f[1], f[2]);
			end
			endcase
			for (int n = 0; n < 75; n++) begin
				if (n % 25 == 0) no_gap = $urandom_range(0, 2) == 0;
				send_tri(random_tri());
			end
		end
		start <= 0;

		while (pending.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

[files.f]
sv/rth_pkg.sv
sv/rth_front.sv
sv/rth_queue.sv
sv/rth_back.sv
sv/ray_triangle_hit_test.sv
sv/rth_checker.sv
sim/tb_ray_triangle_hit_test.sv
